// ===== rtl/cdvf_pkg.sv =====
// shared types, constants and register codes for the co2 dosing valve and fan controller
`timescale 1ns / 1ps

package cdvf_pkg;

  // field widths
  localparam int PpmW     = 14;
  localparam int TickW    = 16;
  localparam int FanW     = 7;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_CO2_SETPOINT   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SAFETY_LIMIT   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COOLDOWN_TICKS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OPEN_TICKS     = 3'd3;

  // request op codes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // register reset values
  localparam logic [PpmW-1:0]  SetpointReset = 14'd1500;
  localparam logic [PpmW-1:0]  LimitReset    = 14'd2000;
  localparam logic [TickW-1:0] CooldownReset = 16'd30000;
  localparam logic [TickW-1:0] OpenReset     = 16'd2000;

  localparam logic [FanW-1:0]  FanFull = 7'd100;
  localparam logic [FanW-1:0]  FanOff  = 7'd0;
  localparam logic [TickW-1:0] CntMax  = 16'hFFFF;

  typedef struct packed {
    logic [PpmW-1:0]  co2_setpoint;
    logic [PpmW-1:0]  safety_limit;
    logic [TickW-1:0] cooldown_ticks;
    logic [TickW-1:0] open_ticks;
  } cdvf_cfg_t;

  typedef struct packed {
    logic             valve_state;
    logic             safety_latch;
    logic             fan_on;
    logic [TickW-1:0] open_timer;
    logic [TickW-1:0] since_close;
  } cdvf_state_t;

  typedef struct packed {
    logic            valve_open;
    logic [FanW-1:0] fan_percent;
    logic            safety_vent;
    logic            cooldown_done;
  } cdvf_res_t;

endpackage

// ===== rtl/cdvf_if.sv =====
// request and result channel interfaces
`timescale 1ns / 1ps

interface cdvf_in_if;
  import cdvf_pkg::*;
  logic            valid;
  logic            ready;
  logic            op;
  logic [PpmW-1:0] co2_ppm;

  modport source (output valid, output op, output co2_ppm, input ready);
  modport sink   (input valid, input op, input co2_ppm, output ready);
endinterface

interface cdvf_out_if;
  import cdvf_pkg::*;
  logic            valid;
  logic            ready;
  logic            valve_open;
  logic [FanW-1:0] fan_percent;
  logic            safety_vent;
  logic            cooldown_done;

  modport source (output valid, output valve_open, output fan_percent,
                  output safety_vent, output cooldown_done, input ready);
  modport sink   (input valid, input valve_open, input fan_percent,
                  input safety_vent, input cooldown_done, output ready);
endinterface

// ===== rtl/cdvf_core.sv =====
// next-state and result logic for one tick or sample request
`timescale 1ns / 1ps

module cdvf_core
  import cdvf_pkg::*;
(
  input  cdvf_cfg_t       cfg,
  input  cdvf_state_t     st,
  input  logic            op,
  input  logic [PpmW-1:0] co2_ppm,
  output cdvf_state_t     st_nxt,
  output cdvf_res_t       res
);

  // state update
  always_comb begin
    st_nxt = st;
    if (op == OP_TICK) begin
      if (st.since_close != CntMax) begin
        st_nxt.since_close = st.since_close + 16'd1;
      end
      if (st.open_timer != '0) begin
        st_nxt.open_timer = st.open_timer - 16'd1;
        // timer runs out with the valve open
        if (st.open_timer == 16'd1 && st.valve_state) begin
          st_nxt.valve_state = 1'b0;
          st_nxt.open_timer  = '0;
          st_nxt.since_close = '0;
        end
      end
    end else if (co2_ppm > cfg.safety_limit) begin
      // safety vent
      st_nxt.fan_on       = 1'b1;
      st_nxt.safety_latch = 1'b1;
      if (st.valve_state) begin
        st_nxt.valve_state = 1'b0;
        st_nxt.open_timer  = '0;
        st_nxt.since_close = '0;
      end
    end else begin
      if (!st.safety_latch) begin
        st_nxt.fan_on = 1'b0;
      end
      if (st.safety_latch && co2_ppm <= cfg.co2_setpoint) begin
        st_nxt.fan_on       = 1'b0;
        st_nxt.safety_latch = 1'b0;
      end
      if (co2_ppm < cfg.co2_setpoint) begin
        // dose once the cooldown has elapsed
        if (!st.valve_state && st.since_close >= cfg.cooldown_ticks) begin
          st_nxt.valve_state = 1'b1;
          st_nxt.open_timer  = (cfg.open_ticks == '0) ? 16'd1 : cfg.open_ticks;
        end
      end else if (st.valve_state) begin
        // early close at or above setpoint
        st_nxt.valve_state = 1'b0;
        st_nxt.open_timer  = '0;
        st_nxt.since_close = '0;
      end
    end
  end

  // result from the updated state
  always_comb begin
    res.valve_open    = st_nxt.valve_state;
    res.fan_percent   = st_nxt.fan_on ? FanFull : FanOff;
    res.safety_vent   = st_nxt.safety_latch;
    res.cooldown_done = (st_nxt.since_close >= cfg.cooldown_ticks);
  end

endmodule

// ===== rtl/co2_dosing_valve_fan_controller.sv =====
// co2 dosing valve and fan controller top level
// a result becomes valid once its request moves from the input register into the result register
// throughput: one request per cycle while results are taken; a held result stalls the input
// once the input register behind it is full
// the input register feeds one pass of compare and counter logic into the result register
// reset: synchronous active-low rst_n clears valve, latch, fan, timers and the pipeline
// and returns the configuration registers to their default values
`timescale 1ns / 1ps

module co2_dosing_valve_fan_controller
  import cdvf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  cdvf_in_if.sink             in_req,
  cdvf_out_if.source          out_res,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cdvf_cfg_t       cfg_r;
  cdvf_state_t     st_r;
  cdvf_state_t     st_nxt;
  cdvf_res_t       res_nxt;
  cdvf_res_t       res_r;
  logic            in_vld_r;
  logic            in_op_r;
  logic [PpmW-1:0] in_ppm_r;
  logic            out_vld_r;
  logic            advance;

  // pipeline control
  assign advance      = in_vld_r && (!out_vld_r || out_res.ready);
  assign in_req.ready = !in_vld_r || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.co2_setpoint   <= SetpointReset;
      cfg_r.safety_limit   <= LimitReset;
      cfg_r.cooldown_ticks <= CooldownReset;
      cfg_r.open_ticks     <= OpenReset;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CO2_SETPOINT:   cfg_r.co2_setpoint   <= cfg_wdata[PpmW-1:0];
        REG_SAFETY_LIMIT:   cfg_r.safety_limit   <= cfg_wdata[PpmW-1:0];
        REG_COOLDOWN_TICKS: cfg_r.cooldown_ticks <= cfg_wdata[TickW-1:0];
        REG_OPEN_TICKS:     cfg_r.open_ticks     <= cfg_wdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_req.ready) begin
      in_vld_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      in_op_r  <= in_req.op;
      in_ppm_r <= in_req.co2_ppm;
    end
  end

  cdvf_core u_core (
    .cfg     (cfg_r),
    .st      (st_r),
    .op      (in_op_r),
    .co2_ppm (in_ppm_r),
    .st_nxt  (st_nxt),
    .res     (res_nxt)
  );

  // controller state, updated as each request moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_res.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid         = out_vld_r;
  assign out_res.valve_open    = res_r.valve_open;
  assign out_res.fan_percent   = res_r.fan_percent;
  assign out_res.safety_vent   = res_r.safety_vent;
  assign out_res.cooldown_done = res_r.cooldown_done;

`ifndef SYNTHESIS
  // valve is never open while safety venting
  a_no_open_in_vent: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.valve_state && st_r.safety_latch))
    else $error("valve open with safety latch set");

  // one-shot timer runs exactly while the valve is open
  a_timer_tracks_valve: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.valve_state == (st_r.open_timer != '0))
    else $error("open timer out of step with valve");

  // fan follows the safety latch
  a_fan_tracks_latch: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.fan_on == st_r.safety_latch)
    else $error("fan state differs from safety latch");

  // state changes only when a request moves to the result register
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(st_r))
    else $error("state changed without a request");
`endif

endmodule
